>>> rtl/core/window_max_pool_int8_unit_defines.svh
// Assertion macros shared by the window max pool RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef WINDOW_MAX_POOL_INT8_UNIT_DEFINES_SVH
`define WINDOW_MAX_POOL_INT8_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wmp_pkg.sv
// Shared types, sizes and codes for the window max pool unit.
// No dependencies; used by wmp_pool_engine and window_max_pool_int8_unit.
package wmp_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int CHANNELS   = 64;
  localparam int MAX_KERNEL = 8;
  localparam int OUT_SHIFT  = 0;

  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  localparam int DIM_W      = 6;   // col/row/channel and image size fields
  localparam int KER_W      = 4;   // kernel and stride fields
  localparam int PAD_W      = 3;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int POS_W      = 12;  // two's complement window position

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_POOL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd7;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = 8'h80;

  typedef struct packed {
    logic [DIM_W-1:0] in_width;
    logic [DIM_W-1:0] in_height;
    logic [KER_W-1:0] kernel_width;
    logic [KER_W-1:0] kernel_height;
    logic [KER_W-1:0] stride_cols;
    logic [KER_W-1:0] stride_rows;
    logic [PAD_W-1:0] pad_cols;
    logic [PAD_W-1:0] pad_rows;
  } cfg_t;

  typedef struct packed {
    logic                     op;
    logic [DIM_W-1:0]         col;
    logic [DIM_W-1:0]         row;
    logic [DIM_W-1:0]         channel;
    logic signed [DATA_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pooled;
    logic                     empty_window;
  } out_t;

endpackage

>>> rtl/core/window_max_pool_int8_unit.sv
// Top level of the int8 window max pool unit: config registers, handshakes,
// output register. Depends on wmp_pkg and wmp_pool_engine.

// Holds a 32 x 32 x 64 signed 8-bit feature map (row, column, channel order)
// in one on-chip memory. A store beat (op 0) writes one sample; stores
// outside the configured image are dropped. A pool beat (op 1)
// walks the kernel window starting at (col*stride_cols - pad_cols,
// row*stride_rows - pad_rows), skips positions outside the image, and
// returns the maximum shifted left by OUT_SHIFT, wrapped to 8 bits; an
// empty window returns -128 with empty_window set. Kernel sides saturate at
// 8. A pool beat holds in_ready low through setup, the walk over the window
// positions, a compare drain and the result hand-off; when either kernel side
// is zero the walk and drain are skipped. The walk length is set by the
// single memory read port: one window position is read per cycle and fed
// to one shared compare. in_ready also stays low while a finished result
// cannot yet move into the output register.
// The map is not cleared at reset: reading an entry never stored returns
// whatever the memory holds. Configuration is written only while idle: the user
// must keep to this, the block itself does not enforce it.
module window_max_pool_int8_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wmp_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wmp_pkg::out_t                     out_data
);

  wmp_pkg::cfg_t cfg;
  wmp_pkg::out_t res;
  logic          busy;
  logic          res_valid;
  logic          res_ready;
  logic          start;

  // Config registers: data is truncated to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width      <= 6'd32;
      cfg.in_height     <= 6'd32;
      cfg.kernel_width  <= 4'd2;
      cfg.kernel_height <= 4'd2;
      cfg.stride_cols   <= 4'd2;
      cfg.stride_rows   <= 4'd2;
      cfg.pad_cols      <= 3'd0;
      cfg.pad_rows      <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmp_pkg::REG_IN_WIDTH:      cfg.in_width      <= cfg_data;
        wmp_pkg::REG_IN_HEIGHT:     cfg.in_height     <= cfg_data;
        wmp_pkg::REG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[3:0];
        wmp_pkg::REG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[3:0];
        wmp_pkg::REG_STRIDE_COLS:   cfg.stride_cols   <= cfg_data[3:0];
        wmp_pkg::REG_STRIDE_ROWS:   cfg.stride_rows   <= cfg_data[3:0];
        wmp_pkg::REG_PAD_COLS:      cfg.pad_cols      <= cfg_data[2:0];
        wmp_pkg::REG_PAD_ROWS:      cfg.pad_rows      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The engine takes one beat at a time; stores retire in the accept cycle.
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  wmp_pool_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .beat      (in_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: frees the engine as soon as the result is captured.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

endmodule

>>> rtl/core/wmp_pool_engine.sv
// Feature map memory, window sequencer and shared max compare.
// Depends on wmp_pkg and window_max_pool_int8_unit_defines.svh.
`include "window_max_pool_int8_unit_defines.svh"

module wmp_pool_engine (
  input  logic          clk,
  input  logic          rst,
  input  wmp_pkg::cfg_t cfg,
  input  logic          start,
  input  wmp_pkg::in_t  beat,
  output logic          busy,
  output logic          res_valid,
  output wmp_pkg::out_t res,
  input  logic          res_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int PW = wmp_pkg::POS_W;
  localparam int KW = wmp_pkg::KER_W + 1;
  localparam int DW = wmp_pkg::DIM_W + 1;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [wmp_pkg::DATA_W-1:0] mem [wmp_pkg::MAP_DEPTH];
  logic [wmp_pkg::DATA_W-1:0] rdata;

  logic [wmp_pkg::DIM_W-1:0] pool_col;
  logic [wmp_pkg::DIM_W-1:0] pool_row;
  logic [wmp_pkg::DIM_W-1:0] pool_ch;
  logic [PW-1:0]             x0;
  logic [PW-1:0]             y0;
  logic [KW-1:0]             kx;
  logic [KW-1:0]             ky;
  logic                      rd_pend;
  logic                      found;
  logic signed [wmp_pkg::DATA_W-1:0] best;

  logic [DW-1:0]             w_eff;
  logic [DW-1:0]             h_eff;
  logic [KW-1:0]             kw_eff;
  logic [KW-1:0]             kh_eff;
  logic [PW-1:0]             x;
  logic [PW-1:0]             y;
  logic                      in_img;
  logic                      last_col;
  logic                      last_pos;
  logic                      store_ok;
  logic                      ch_ok;
  logic [wmp_pkg::MAP_AW-1:0] waddr;
  logic [wmp_pkg::MAP_AW-1:0] raddr;

  // Effective sizes, saturated to the build limits.
  assign w_eff  = (DW'(cfg.in_width) > DW'(wmp_pkg::MAX_WIDTH)) ?
                  DW'(wmp_pkg::MAX_WIDTH) : DW'(cfg.in_width);
  assign h_eff  = (DW'(cfg.in_height) > DW'(wmp_pkg::MAX_HEIGHT)) ?
                  DW'(wmp_pkg::MAX_HEIGHT) : DW'(cfg.in_height);
  assign kw_eff = (KW'(cfg.kernel_width) > KW'(wmp_pkg::MAX_KERNEL)) ?
                  KW'(wmp_pkg::MAX_KERNEL) : KW'(cfg.kernel_width);
  assign kh_eff = (KW'(cfg.kernel_height) > KW'(wmp_pkg::MAX_KERNEL)) ?
                  KW'(wmp_pkg::MAX_KERNEL) : KW'(cfg.kernel_height);

  assign store_ok = (DW'(beat.col) < w_eff) && (DW'(beat.row) < h_eff) &&
                    (DW'(beat.channel) < DW'(wmp_pkg::CHANNELS));
  assign ch_ok    = DW'(pool_ch) < DW'(wmp_pkg::CHANNELS);

  assign waddr = wmp_pkg::MAP_AW'((32'(beat.row) * wmp_pkg::MAX_WIDTH + 32'(beat.col))
                 * wmp_pkg::CHANNELS + 32'(beat.channel));

  // Current window position; negative values have the top bit set.
  assign x      = x0 + PW'(kx);
  assign y      = y0 + PW'(ky);
  assign in_img = !x[PW-1] && (x < PW'(w_eff)) && !y[PW-1] && (y < PW'(h_eff));
  assign raddr  = wmp_pkg::MAP_AW'((32'(y) * wmp_pkg::MAX_WIDTH + 32'(x))
                  * wmp_pkg::CHANNELS + 32'(pool_ch));

  assign last_col = (kx == kw_eff - KW'(1));
  assign last_pos = last_col && (ky == kh_eff - KW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && beat.op == wmp_pkg::OP_POOL) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (kw_eff == '0 || kh_eff == '0 || !ch_ok) state_next = S_DONE;
        else state_next = S_WALK;
      end
      S_WALK: begin
        if (last_pos) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      state <= state_next;
      rd_pend <= (state == S_WALK) && in_img;
      if (state == S_SETUP) begin
        found <= 1'b0;
      end else if (rd_pend && (!found || $signed(rdata) > best)) begin
        found <= 1'b1;
      end
    end
  end

  // Shared compare: one sample per cycle, in the cycle after its read.
  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      best <= -8'sd128;
    end else if (rd_pend && (!found || $signed(rdata) > best)) begin
      best <= $signed(rdata);
    end
  end

  // Request capture and window walk counters.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      pool_col <= beat.col;
      pool_row <= beat.row;
      pool_ch  <= beat.channel;
    end
    if (state == S_SETUP) begin
      x0 <= PW'(pool_col) * PW'(cfg.stride_cols) - PW'(cfg.pad_cols);
      y0 <= PW'(pool_row) * PW'(cfg.stride_rows) - PW'(cfg.pad_rows);
      kx <= '0;
      ky <= '0;
    end else if (state == S_WALK) begin
      if (last_col) begin
        kx <= '0;
        ky <= ky + KW'(1);
      end else begin
        kx <= kx + KW'(1);
      end
    end
  end

  // Feature map: one write port for stores, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && beat.op == wmp_pkg::OP_STORE && store_ok) begin
      mem[waddr] <= beat.sample;
    end
    if (state == S_WALK && in_img) begin
      rdata <= mem[raddr];
    end
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.pooled       = found ? wmp_pkg::DATA_W'(best <<< wmp_pkg::OUT_SHIFT)
                                  : wmp_pkg::EMPTY_VALUE;
  assign res.empty_window = !found;

  `WMP_ASSERT_NOW(a_start_idle, start, state == S_IDLE, "beat accepted while engine busy")
  `WMP_ASSERT_NEXT(a_read_from_walk, (state == S_WALK) && in_img, rd_pend, "read lost")
  `WMP_ASSERT_NOW(a_walk_bounds, state == S_WALK, (kx < kw_eff) && (ky < kh_eff),
                  "window counter out of kernel")
  `WMP_ASSERT_NOW(a_found_source, $rose(found),
                  ($past(state) == S_WALK) || ($past(state) == S_DRAIN),
                  "maximum seeded outside window walk")

endmodule

>>> test/tb_window_max_pool_int8_unit.sv
// Self-checking testbench for window_max_pool_int8_unit: stores samples into the
// feature map and checks pooled results against a behavioral window-max predictor.
// Depends on wmp_pkg and the unit RTL only.
`timescale 1ns / 100ps

module tb_window_max_pool_int8_unit;

  localparam int PHASES         = 10;
  localparam int RAND_PER_PHASE = 110;
  localparam int DRAIN_CYCLES   = 80;    // covers an 8x8 walk, plus margin
  localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before giving up

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [wmp_pkg::CFG_IDX_W-1:0]  cfg_index = wmp_pkg::REG_IN_WIDTH;
  logic [wmp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  wmp_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  wmp_pkg::out_t                  out_data;

  window_max_pool_int8_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Beats waiting to be offered, and pooled results still owed by the unit.
  wmp_pkg::in_t  beats_to_send[$];
  wmp_pkg::out_t awaited_pool[$];

  // Current register values, mirrored as they are written.
  wmp_pkg::cfg_t cfg_now;

  // Predictor copy of the map, plus the generator's record of which entries
  // hold a sample (pools are only issued over written entries).
  logic signed [wmp_pkg::DATA_W-1:0] shadow_map [wmp_pkg::MAP_DEPTH];
  bit                                map_written [wmp_pkg::MAP_DEPTH];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  int          failures = 0;
  int          queued = 0;
  int          stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers on the mirrored configuration
  // ---------------------------------------------------------------------------
  function automatic int eff_w();
    return (int'(cfg_now.in_width) > wmp_pkg::MAX_WIDTH) ? wmp_pkg::MAX_WIDTH :
           int'(cfg_now.in_width);
  endfunction

  function automatic int eff_h();
    return (int'(cfg_now.in_height) > wmp_pkg::MAX_HEIGHT) ? wmp_pkg::MAX_HEIGHT :
           int'(cfg_now.in_height);
  endfunction

  function automatic int eff_kw();
    return (int'(cfg_now.kernel_width) > wmp_pkg::MAX_KERNEL) ? wmp_pkg::MAX_KERNEL :
           int'(cfg_now.kernel_width);
  endfunction

  function automatic int eff_kh();
    return (int'(cfg_now.kernel_height) > wmp_pkg::MAX_KERNEL) ? wmp_pkg::MAX_KERNEL :
           int'(cfg_now.kernel_height);
  endfunction

  // Map layout: row major, channel innermost.
  function automatic int map_addr(int x, int y, int ch);
    return (y * wmp_pkg::MAX_WIDTH + x) * wmp_pkg::CHANNELS + ch;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Window origin may be negative with padding; out-of-image positions are
  // skipped and the first in-image sample seeds the running max.
  function automatic wmp_pkg::out_t window_max(int c, int r, int ch);
    int w, h, x0, y0;
    bit found;
    logic signed [wmp_pkg::DATA_W-1:0] best, v;
    wmp_pkg::out_t res;
    w = eff_w();
    h = eff_h();
    x0 = c * int'(cfg_now.stride_cols) - int'(cfg_now.pad_cols);
    y0 = r * int'(cfg_now.stride_rows) - int'(cfg_now.pad_rows);
    found = 1'b0;
    best = '0;
    if (ch < wmp_pkg::CHANNELS) begin
      for (int y = y0; y < y0 + eff_kh(); y++) begin
        if (y < 0 || y >= h) continue;
        for (int x = x0; x < x0 + eff_kw(); x++) begin
          if (x < 0 || x >= w) continue;
          v = shadow_map[map_addr(x, y, ch)];
          if (!found || v > best) begin
            best = v;
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      res.pooled = best << wmp_pkg::OUT_SHIFT;  // wraps at 8 bits
      res.empty_window = 1'b0;
    end else begin
      res.pooled = wmp_pkg::EMPTY_VALUE;
      res.empty_window = 1'b1;
    end
    return res;
  endfunction

  // Called for every accepted input beat, in acceptance order.
  function automatic void apply_beat(wmp_pkg::in_t b);
    if (b.op == wmp_pkg::OP_STORE) begin
      if (int'(b.col) < eff_w() && int'(b.row) < eff_h() &&
          int'(b.channel) < wmp_pkg::CHANNELS)
        shadow_map[map_addr(int'(b.col), int'(b.row), int'(b.channel))] = b.sample;
    end else begin
      awaited_pool.push_back(window_max(int'(b.col), int'(b.row), int'(b.channel)));
    end
  endfunction

  function automatic void check_result(wmp_pkg::out_t got);
    wmp_pkg::out_t want;
    if (awaited_pool.size() == 0) begin
      $error("unexpected result beat: pooled %0d empty_window %0b",
             got.pooled, got.empty_window);
      failures++;
      return;
    end
    want = awaited_pool.pop_front();
    if (got.pooled !== want.pooled) begin
      $error("pooled: expected %0d, got %0d", want.pooled, got.pooled);
      failures++;
    end
    if (got.empty_window !== want.empty_window) begin
      $error("empty_window: expected %0b, got %0b", want.empty_window, got.empty_window);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void push_store(int c, int r, int ch, int s);
    wmp_pkg::in_t b;
    b = '0;
    b.op = wmp_pkg::OP_STORE;
    b.col = wmp_pkg::DIM_W'(c);
    b.row = wmp_pkg::DIM_W'(r);
    b.channel = wmp_pkg::DIM_W'(ch);
    b.sample = wmp_pkg::DATA_W'(s);
    if (c < eff_w() && r < eff_h()) map_written[map_addr(c, r, ch)] = 1'b1;
    beats_to_send.push_back(b);
    queued++;
  endfunction

  // Any in-image window position not yet written gets a random store first,
  // so a pool never touches an undefined map entry.
  function automatic void push_pool(int c, int r, int ch);
    int w, h, x0, y0;
    wmp_pkg::in_t b;
    w = eff_w();
    h = eff_h();
    x0 = c * int'(cfg_now.stride_cols) - int'(cfg_now.pad_cols);
    y0 = r * int'(cfg_now.stride_rows) - int'(cfg_now.pad_rows);
    for (int y = y0; y < y0 + eff_kh(); y++) begin
      for (int x = x0; x < x0 + eff_kw(); x++) begin
        if (x >= 0 && x < w && y >= 0 && y < h && !map_written[map_addr(x, y, ch)])
          push_store(x, y, ch, int'($urandom_range(255)));
      end
    end
    b = '0;
    b.op = wmp_pkg::OP_POOL;
    b.col = wmp_pkg::DIM_W'(c);
    b.row = wmp_pkg::DIM_W'(r);
    b.channel = wmp_pkg::DIM_W'(ch);
    b.sample = wmp_pkg::DATA_W'($urandom_range(255));  // don't-care for pool
    beats_to_send.push_back(b);
    queued++;
  endfunction

  // A few favorite channels (all-zero, all-one, alternating bits) so windows
  // get reused; occasionally any channel.
  function automatic int pick_channel();
    case ($urandom_range(4))
      0: return 0;
      1: return 63;
      2: return 21;
      3: return 42;
      default: return int'($urandom_range(63));
    endcase
  endfunction

  // Output position on one axis, mostly in a range near the image; sometimes any value.
  function automatic int pick_out_pos(int extent, int pad, int stride);
    int top;
    if (stride == 0 || $urandom_range(99) < 15) return int'($urandom_range(63));
    top = (extent + pad) / stride;
    if (top > 63) top = 63;
    return int'($urandom_range(top));
  endfunction

  task automatic random_items(int n);
    int start, pick;
    start = queued;
    while (queued - start < n) begin
      pick = int'($urandom_range(99));
      if (pick < 40) begin
        // well-formed store inside the image in use
        push_store((eff_w() > 0) ? int'($urandom_range(eff_w() - 1)) :
                                   int'($urandom_range(63)),
                   (eff_h() > 0) ? int'($urandom_range(eff_h() - 1)) :
                                   int'($urandom_range(63)),
                   pick_channel(), int'($urandom_range(255)));
      end else if (pick < 50) begin
        // noise: any field value, often outside the image and dropped
        push_store(int'($urandom_range(63)), int'($urandom_range(63)),
                   int'($urandom_range(63)), int'($urandom_range(255)));
      end else begin
        push_pool(pick_out_pos(eff_w(), int'(cfg_now.pad_cols), int'(cfg_now.stride_cols)),
                  pick_out_pos(eff_h(), int'(cfg_now.pad_rows), int'(cfg_now.stride_rows)),
                  pick_channel());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes: one per clock, idle unit only
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [wmp_pkg::CFG_IDX_W-1:0] idx,
                           logic [wmp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_config(wmp_pkg::cfg_t c);
    write_reg(wmp_pkg::REG_IN_WIDTH, c.in_width);
    write_reg(wmp_pkg::REG_IN_HEIGHT, c.in_height);
    write_reg(wmp_pkg::REG_KERNEL_WIDTH, wmp_pkg::CFG_DATA_W'(c.kernel_width));
    write_reg(wmp_pkg::REG_KERNEL_HEIGHT, wmp_pkg::CFG_DATA_W'(c.kernel_height));
    write_reg(wmp_pkg::REG_STRIDE_COLS, wmp_pkg::CFG_DATA_W'(c.stride_cols));
    write_reg(wmp_pkg::REG_STRIDE_ROWS, wmp_pkg::CFG_DATA_W'(c.stride_rows));
    write_reg(wmp_pkg::REG_PAD_COLS, wmp_pkg::CFG_DATA_W'(c.pad_cols));
    write_reg(wmp_pkg::REG_PAD_ROWS, wmp_pkg::CFG_DATA_W'(c.pad_rows));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  // Wait until every beat is sent and every result back, then let a trailing
  // store (which has no result) finish inside the unit.
  task automatic settle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || awaited_pool.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers queued beats, holds payload until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) apply_beat(in_data);
      if (!in_valid || in_ready) begin
        if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= beats_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each result beat, drives random back-pressure
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_taken;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (long_hold_req && !hold_taken) begin
        // long stall so the unit backs up and drops in_ready
        hold_taken <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: consecutive cycles without a beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("window_max_pool_int8_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    wmp_pkg::cfg_t next_cfg;
    cfg_now = '{6'd32, 6'd32, 4'd2, 4'd2, 4'd2, 4'd2, 3'd0, 3'd0};  // reset values
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          // largest effective kernel, stride 8 and largest padding
          1: next_cfg = '{6'd32, 6'd32, 4'd8, 4'd8, 4'd8, 4'd8, 3'd7, 3'd7};
          // single-pixel image and kernel
          2: next_cfg = '{6'd1, 6'd1, 4'd1, 4'd1, 4'd1, 4'd1, 3'd0, 3'd0};
          3: next_cfg = '{6'd17, 6'd9, 4'd3, 4'd5, 4'd1, 4'd2, 3'd1, 3'd2};
          // zero-width kernel (all windows empty), zero column stride,
          // image sizes above the maximum
          4: next_cfg = '{6'd40, 6'd63, 4'd0, 4'd5, 4'd0, 4'd3, 3'd2, 3'd0};
          // no image at all: stores dropped, pools empty
          5: next_cfg = '{6'd0, 6'd12, 4'd3, 4'd3, 4'd1, 4'd1, 3'd0, 3'd0};
          // oversized kernel saturates to 8x8
          6: next_cfg = '{6'd63, 6'd20, 4'd12, 4'd15, 4'd0, 4'd1, 3'd7, 3'd3};
          default: begin
            next_cfg.in_width = wmp_pkg::DIM_W'($urandom_range(32, 1));
            next_cfg.in_height = wmp_pkg::DIM_W'($urandom_range(32, 1));
            next_cfg.kernel_width = wmp_pkg::KER_W'($urandom_range(8, 1));
            next_cfg.kernel_height = wmp_pkg::KER_W'($urandom_range(8, 1));
            next_cfg.stride_cols = ($urandom_range(9) == 0) ? '0 :
                                   wmp_pkg::KER_W'($urandom_range(8, 1));
            next_cfg.stride_rows = ($urandom_range(9) == 0) ? '0 :
                                   wmp_pkg::KER_W'($urandom_range(8, 1));
            next_cfg.pad_cols = wmp_pkg::PAD_W'($urandom_range(7));
            next_cfg.pad_rows = wmp_pkg::PAD_W'($urandom_range(7));
          end
        endcase
        apply_config(next_cfg);
      end

      // sender lightly idle / receiver heavily, then swapped, then none
      if (ph < 4) begin
        send_idle_pct = 11;
        recv_idle_pct = 47;
      end else if (ph < 7) begin
        send_idle_pct = 47;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 0) begin
        // Directed: extreme samples, all-negative window, corner of the map,
        // dropped stores just past each edge, windows fully outside the image.
        push_store(0, 0, 0, 8'h80);
        push_store(1, 0, 0, 8'h7f);
        push_store(0, 1, 0, 8'h00);
        push_store(1, 1, 0, 8'hff);
        push_pool(0, 0, 0);
        push_store(2, 0, 21, 8'hfb);
        push_store(3, 0, 21, 8'hfd);
        push_store(2, 1, 21, 8'h80);
        push_store(3, 1, 21, 8'hf9);
        push_pool(1, 0, 21);
        push_store(31, 31, 63, 8'h55);
        push_store(30, 31, 63, 8'haa);
        push_pool(15, 15, 63);
        push_store(63, 63, 42, 8'h11);
        push_store(32, 5, 42, 8'h22);
        push_store(5, 32, 42, 8'h33);
        push_pool(63, 63, 42);
        push_pool(16, 0, 0);
        push_pool(0, 0, 0);
      end

      if (ph == 2) long_hold_req = 1'b1;
      random_items(RAND_PER_PHASE);
    end

    settle();
    if (failures == 0 && awaited_pool.size() == 0) begin
      $display("window_max_pool_int8_unit test passed");
    end else begin
      $display("window_max_pool_int8_unit test failed");
    end
    $finish;
  end

endmodule
